// ===== rtl/core/e2r_pkg.sv =====
// ----------------------------------------------------------------------------
// e2r_pkg
// shared constants and helpers for the euler angle to rotation matrix block
// ----------------------------------------------------------------------------
package e2r_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int OUT_FRAC_BITS_DEF = 14;
  localparam int CORDIC_STEPS      = 30;
  localparam int ACC_W             = 34;   // q2.30 plus headroom
  localparam int TURN_W            = 32;

  localparam logic signed [ACC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef logic signed [ACC_W-1:0] acc_t;

  // arctangent table in turn units
  function automatic logic signed [TURN_W+1:0] atan_turn(input int idx);
    logic signed [TURN_W+1:0] v;
    case (idx)
      0:  v = 34'sh20000000;  1:  v = 34'sh12E4051E;  2:  v = 34'sh09FB385B;
      3:  v = 34'sh051111D4;  4:  v = 34'sh028B0D43;  5:  v = 34'sh0145D7E1;
      6:  v = 34'sh00A2F61E;  7:  v = 34'sh00517C55;  8:  v = 34'sh0028BE53;
      9:  v = 34'sh00145F2F;  10: v = 34'sh000A2F98;  11: v = 34'sh000517CC;
      12: v = 34'sh00028BE6;  13: v = 34'sh000145F3;  14: v = 34'sh0000A2F9;
      15: v = 34'sh0000517C;  16: v = 34'sh000028BE;  17: v = 34'sh0000145F;
      18: v = 34'sh00000A2F;  19: v = 34'sh00000517;  20: v = 34'sh0000028B;
      21: v = 34'sh00000145;  22: v = 34'sh000000A2;  23: v = 34'sh00000051;
      24: v = 34'sh00000028;  25: v = 34'sh00000014;  26: v = 34'sh0000000A;
      27: v = 34'sh00000005;  28: v = 34'sh00000002;  29: v = 34'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

  // q2.30 product with round half up, floor shift
  function automatic acc_t mul30(input acc_t a, input acc_t b);
    logic signed [2*ACC_W-1:0] p;
    p = a * b + (68'sd1 <<< 29);
    return acc_t'(p >>> 30);
  endfunction

endpackage

// ===== rtl/core/euler_to_rotation_matrix.sv =====
// pipeline: 1 fold stage, 30 cordic steps, 2 product stages, 1 rounding and
//   output register from input word to output word
// throughput: one word per cycle when not stalled, set by the fully pipelined cordic and products
// a stall freezes the whole pipeline; nothing is lost or repeated
// reset: synchronous active low, clears the valid bits only
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// zyx direction cosine matrix from roll, pitch and yaw binary angles
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix #(
  parameter int ANGLE_BITS    = e2r_pkg::ANGLE_BITS_DEF,
  parameter int OUT_FRAC_BITS = e2r_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [ANGLE_BITS-1:0] in_roll_angle,
  input  logic signed [ANGLE_BITS-1:0] in_pitch_angle,
  input  logic signed [ANGLE_BITS-1:0] in_yaw_angle,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [OUT_FRAC_BITS+1:0] out_r00, out_r01, out_r02,
  output logic signed [OUT_FRAC_BITS+1:0] out_r10, out_r11, out_r12,
  output logic signed [OUT_FRAC_BITS+1:0] out_r20, out_r21, out_r22
);
  // cordic: 31 register stages, matrix: 3 stages
  localparam int DEPTH = e2r_pkg::CORDIC_STEPS + 1 + 3;

  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic en;
  e2r_pkg::acc_t sr, cr, sp, cp, sy, cy;
  logic signed [OUT_FRAC_BITS+1:0] m [9];

  // the whole pipeline advances unless a finished word is held at the output
  assign en       = !(out_stall && vld_r[DEPTH-1]);
  assign in_stall = !en;
  assign vld_nxt  = {vld_r[DEPTH-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  e2r_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk(clk), .en(en), .angle(in_roll_angle), .sin_o(sr), .cos_o(cr));
  e2r_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk(clk), .en(en), .angle(in_pitch_angle), .sin_o(sp), .cos_o(cp));
  e2r_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk(clk), .en(en), .angle(in_yaw_angle), .sin_o(sy), .cos_o(cy));

  e2r_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mat (
    .clk(clk), .en(en), .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy),
    .m_o(m));

  assign out_valid = vld_r[DEPTH-1];
  assign out_r00 = m[0]; assign out_r01 = m[1]; assign out_r02 = m[2];
  assign out_r10 = m[3]; assign out_r11 = m[4]; assign out_r12 = m[5];
  assign out_r20 = m[6]; assign out_r21 = m[7]; assign out_r22 = m[8];

  // held output word stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_r00) && $stable(out_r22))
    else $error("output word changed under stall");
  // input is refused only when the output is stalled
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
  // diagonal term r22 never exceeds one in magnitude
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_r22 <= (1 <<< OUT_FRAC_BITS) && out_r22 >= -(1 <<< OUT_FRAC_BITS))
    else $error("element out of range");
endmodule

// ===== rtl/core/e2r_cordic.sv =====
// ----------------------------------------------------------------------------
// e2r_cordic
// pipelined sine and cosine, one rotation step per stage
// ----------------------------------------------------------------------------
module e2r_cordic #(
  parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output e2r_pkg::acc_t                sin_o,
  output e2r_pkg::acc_t                cos_o
);
  localparam int N  = e2r_pkg::CORDIC_STEPS;
  localparam int ZW = e2r_pkg::TURN_W + 2;

  e2r_pkg::acc_t          x_r [N+1];
  e2r_pkg::acc_t          y_r [N+1];
  logic signed [ZW-1:0]   z_r [N+1];
  logic                   flip_r [N+1];

  logic signed [ZW-1:0] z0;
  logic                 f0;

  // angle to turn fraction, fold into +-quarter turn
  always_comb begin
    z0 = ZW'(signed'({angle, {(e2r_pkg::TURN_W-ANGLE_BITS){1'b0}}}));
    f0 = 1'b0;
    if (z0 > (ZW'(1) <<< 30)) begin
      z0 = z0 - (ZW'(1) <<< 31);
      f0 = 1'b1;
    end else if (z0 < -(ZW'(1) <<< 30)) begin
      z0 = z0 + (ZW'(1) <<< 31);
      f0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= e2r_pkg::CORDIC_GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= z0;
      flip_r[0] <= f0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - e2r_pkg::atan_turn(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + e2r_pkg::atan_turn(i);
        end
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  assign sin_o = flip_r[N] ? -y_r[N] : y_r[N];
  assign cos_o = flip_r[N] ? -x_r[N] : x_r[N];
endmodule

// ===== rtl/core/e2r_matrix.sv =====
// ----------------------------------------------------------------------------
// e2r_matrix
// two product stages, rounding and saturation of the nine elements
// ----------------------------------------------------------------------------
module e2r_matrix #(
  parameter int OUT_FRAC_BITS = e2r_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  e2r_pkg::acc_t sr, cr, sp, cp, sy, cy,
  output logic signed [OUT_FRAC_BITS+1:0] m_o [9]
);
  localparam int OW = OUT_FRAC_BITS + 2;
  localparam int SH = 30 - OUT_FRAC_BITS;
  typedef e2r_pkg::acc_t acc_t;

  // stage a: pairwise products
  acc_t srsp_r, crsp_r, spcr_r, sr_a, cr_a, sp_a, sy_a, cy_a;
  acc_t p00_r, p01_r, p12_r, p22_r;
  // stage b: triple and cross products
  acc_t t10a_r, t10b_r, t11a_r, t11b_r, t20a_r, t20b_r, t21a_r, t21b_r;
  acc_t b00_r, b01_r, b02_r, b12_r, b22_r;
  acc_t e [9];

  always_ff @(posedge clk) begin
    if (en) begin
      srsp_r <= e2r_pkg::mul30(sr, sp);
      crsp_r <= e2r_pkg::mul30(cr, sp);
      spcr_r <= e2r_pkg::mul30(sp, cr);
      p00_r  <= e2r_pkg::mul30(cp, cy);
      p01_r  <= e2r_pkg::mul30(cp, sy);
      p12_r  <= e2r_pkg::mul30(sr, cp);
      p22_r  <= e2r_pkg::mul30(cp, cr);
      sr_a <= sr; cr_a <= cr; sp_a <= sp; sy_a <= sy; cy_a <= cy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t10a_r <= e2r_pkg::mul30(srsp_r, cy_a);
      t10b_r <= e2r_pkg::mul30(cr_a, sy_a);
      t11a_r <= e2r_pkg::mul30(cr_a, cy_a);
      t11b_r <= e2r_pkg::mul30(srsp_r, sy_a);
      t20a_r <= e2r_pkg::mul30(crsp_r, cy_a);
      t20b_r <= e2r_pkg::mul30(sr_a, sy_a);
      t21a_r <= e2r_pkg::mul30(spcr_r, sy_a);
      t21b_r <= e2r_pkg::mul30(sr_a, cy_a);
      b00_r <= p00_r; b01_r <= p01_r; b02_r <= -sp_a;
      b12_r <= p12_r; b22_r <= p22_r;
    end
  end

  always_comb begin
    e[0] = b00_r;           e[1] = b01_r;           e[2] = b02_r;
    e[3] = t10a_r - t10b_r; e[4] = t11a_r + t11b_r; e[5] = b12_r;
    e[6] = t20a_r + t20b_r; e[7] = t21a_r - t21b_r; e[8] = b22_r;
  end

  for (genvar k = 0; k < 9; k++) begin : g_out
    acc_t r;
    always_comb begin
      if (SH > 0) r = (e[k] + (acc_t'(1) <<< (SH > 0 ? SH-1 : 0))) >>> SH;
      else        r = e[k];
      if (r > (acc_t'(1) <<< OUT_FRAC_BITS))       r = acc_t'(1) <<< OUT_FRAC_BITS;
      else if (r < -(acc_t'(1) <<< OUT_FRAC_BITS)) r = -(acc_t'(1) <<< OUT_FRAC_BITS);
    end
    always_ff @(posedge clk) begin
      if (en) m_o[k] <= r[OW-1:0];
    end
  end
endmodule
